// File: sv/rtfsc_pkg.sv
// shared types and constants for the tick rate freeze and step controller
package rtfsc_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int FRAC_BITS_MIN = 8;
   localparam int FRAC_BITS_MAX = 32;

   localparam int OP_W     = 2;
   localparam int STEP_W   = 16;
   localparam int FACTOR_W = 23;
   localparam int TICKS_W  = 16;
   localparam int CAP_W    = 16;

   localparam logic [CAP_W-1:0] STEP_CAP_RESET = 16'd1200;
   localparam int WARP_MAX_INT = 100;

   typedef enum logic [OP_W-1:0] {
      OP_FRAME  = 2'd0,
      OP_FREEZE = 2'd1,
      OP_STEP   = 2'd2,
      OP_WARP   = 2'd3
   } op_type;

   typedef struct packed {
      op_type               op;
      logic                 freeze_on;
      logic [STEP_W-1:0]    step_count;
      logic [FACTOR_W-1:0]  warp_factor;
   } cmd_type;

   typedef struct packed {
      logic [TICKS_W-1:0] ticks_to_run;
      logic               accepted;
   } rsp_type;

endpackage

// File: sv/rtfsc_in_reg.sv
// input register holding one command item
module rtfsc_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  rtfsc_pkg::cmd_type req_cmd,
   input  logic               advance,
   output logic               cmd_valid,
   output rtfsc_pkg::cmd_type cmd
);

   logic               vld_ff;
   logic               vld_in;
   rtfsc_pkg::cmd_type cmd_ff;
   logic               load;

   assign load = req_valid && !req_stall;

   always_comb begin
      if (load) begin
         vld_in = 1'b1;
      end else if (advance) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= req_cmd;
      end
   end

   assign cmd_valid = vld_ff;
   assign cmd       = cmd_ff;

endmodule

// File: sv/rtfsc_engine.sv
// controller state and single pass command evaluation
module rtfsc_engine #(
   parameter int FRAC_BITS = rtfsc_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [rtfsc_pkg::CAP_W-1:0]   csr_write_data,
   input  logic                          fire,
   input  rtfsc_pkg::cmd_type            cmd,
   output rtfsc_pkg::rsp_type            rsp
);

   localparam int RATE_W = (FRAC_BITS + 1 > rtfsc_pkg::FACTOR_W) ?
                           FRAC_BITS + 1 : rtfsc_pkg::FACTOR_W;
   localparam int SUM_W  = RATE_W + 1;
   localparam int CMP_W  = (FRAC_BITS + 7 > rtfsc_pkg::FACTOR_W) ?
                           FRAC_BITS + 7 : rtfsc_pkg::FACTOR_W;
   localparam logic [CMP_W-1:0]  ONE_CMP  = CMP_W'(1) << FRAC_BITS;
   localparam logic [CMP_W-1:0]  WARP_MAX = CMP_W'(rtfsc_pkg::WARP_MAX_INT) << FRAC_BITS;
   localparam logic [RATE_W-1:0] ONE_RATE = RATE_W'(1) << FRAC_BITS;

   logic [rtfsc_pkg::CAP_W-1:0]  cap_ff;
   logic                         frozen_ff;
   logic                         frozen_in;
   logic [RATE_W-1:0]            rate_ff;
   logic [RATE_W-1:0]            rate_in;
   logic [FRAC_BITS-1:0]         frac_ff;
   logic [FRAC_BITS-1:0]         frac_in;
   logic [rtfsc_pkg::STEP_W-1:0] queued_ff;
   logic [rtfsc_pkg::STEP_W-1:0] queued_in;

   logic [SUM_W-1:0]              sum;
   logic [rtfsc_pkg::STEP_W:0]    queue_sum;
   logic [CMP_W-1:0]              factor_ext;
   logic                          step_ok;
   logic                          warp_ok;

   assign sum        = SUM_W'(frac_ff) + SUM_W'(rate_ff);
   assign queue_sum  = {1'b0, queued_ff} + {1'b0, cmd.step_count};
   assign factor_ext = CMP_W'(cmd.warp_factor);
   assign step_ok    = (cmd.step_count != '0) && frozen_ff &&
                       (queue_sum <= {1'b0, cap_ff});
   assign warp_ok    = (factor_ext != '0) && (factor_ext <= WARP_MAX);

   always_comb begin
      frozen_in        = frozen_ff;
      rate_in          = rate_ff;
      frac_in          = frac_ff;
      queued_in        = queued_ff;
      rsp.ticks_to_run = '0;
      rsp.accepted     = 1'b1;
      case (cmd.op)
         rtfsc_pkg::OP_FRAME: begin
            if (frozen_ff) begin
               rsp.ticks_to_run = queued_ff;
               queued_in        = '0;
            end else begin
               rsp.ticks_to_run = rtfsc_pkg::TICKS_W'(sum >> FRAC_BITS);
               frac_in          = sum[FRAC_BITS-1:0];
            end
         end
         rtfsc_pkg::OP_FREEZE: begin
            frozen_in = cmd.freeze_on;
            if (!cmd.freeze_on) begin
               queued_in = '0;
            end
         end
         rtfsc_pkg::OP_STEP: begin
            rsp.accepted = step_ok;
            if (step_ok) begin
               queued_in = queue_sum[rtfsc_pkg::STEP_W-1:0];
            end
         end
         rtfsc_pkg::OP_WARP: begin
            rsp.accepted = warp_ok;
            if (warp_ok) begin
               rate_in = RATE_W'(cmd.warp_factor);
               if (factor_ext == ONE_CMP) begin
                  frac_in = '0;
               end
            end
         end
         default: begin
            rsp.accepted = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= rtfsc_pkg::STEP_CAP_RESET;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frozen_ff <= 1'b0;
         rate_ff   <= ONE_RATE;
         frac_ff   <= '0;
         queued_ff <= '0;
      end else if (fire) begin
         frozen_ff <= frozen_in;
         rate_ff   <= rate_in;
         frac_ff   <= frac_in;
         queued_ff <= queued_in;
      end
   end

   // queued ticks only exist while frozen
   a_queue_empty_running: assert property (@(posedge clock) disable iff (reset)
      !frozen_ff |-> queued_ff == '0)
      else $error("step ticks queued while running");

   // rejected step leaves the queue alone
   a_reject_keeps_queue: assert property (@(posedge clock) disable iff (reset)
      fire && cmd.op == rtfsc_pkg::OP_STEP && !rsp.accepted |=> $stable(queued_ff))
      else $error("rejected step changed queue");

   // warp never leaves the allowed range
   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(rate_ff) != '0 && CMP_W'(rate_ff) <= WARP_MAX)
      else $error("warp rate out of range");

   // non-frame items carry no ticks
   a_ticks_only_frame: assert property (@(posedge clock) disable iff (reset)
      fire && cmd.op != rtfsc_pkg::OP_FRAME |-> rsp.ticks_to_run == '0)
      else $error("ticks on non-frame item");

endmodule

// File: sv/rtfsc_out_reg.sv
// result register holding one result item
module rtfsc_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  rtfsc_pkg::rsp_type rsp_in_data,
   input  logic               rsp_stall,
   output logic               rsp_valid,
   output rtfsc_pkg::rsp_type rsp
);

   logic               vld_ff;
   logic               vld_in;
   rtfsc_pkg::rsp_type rsp_ff;

   always_comb begin
      if (advance) begin
         vld_in = 1'b1;
      end else begin
         vld_in = vld_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in_data;
      end
   end

   assign rsp_valid = vld_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/tick_rate_freeze_step_control_core.sv
// top level of the tick rate freeze and step controller
// an accepted item passes from the input register to the result register,
// where its result waits to be taken; throughput: one item per cycle while
// results are taken, set by the single state update per item; the input
// register, if empty, accepts a new item while a result waits to be taken
// reset (synchronous): running, warp 1.0, accumulator and step queue clear,
// step cap 1200, both item registers empty
module tick_rate_freeze_step_control_core #(
   parameter int FRAC_BITS = rtfsc_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rtfsc_pkg::OP_W-1:0]        req_op,
   input  logic                              req_freeze_on,
   input  logic [rtfsc_pkg::STEP_W-1:0]      req_step_count,
   input  logic [rtfsc_pkg::FACTOR_W-1:0]    req_warp_factor,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rtfsc_pkg::TICKS_W-1:0]     rsp_ticks_to_run,
   output logic                              rsp_accepted,
   input  logic                              csr_write_enable,
   input  logic [rtfsc_pkg::CAP_W-1:0]       csr_write_data
);

   rtfsc_pkg::cmd_type req_cmd;
   rtfsc_pkg::cmd_type cmd;
   rtfsc_pkg::rsp_type eval_rsp;
   rtfsc_pkg::rsp_type rsp;
   logic               cmd_valid;
   logic               advance;

   assign req_cmd.op          = rtfsc_pkg::op_type'(req_op);
   assign req_cmd.freeze_on   = req_freeze_on;
   assign req_cmd.step_count  = req_step_count;
   assign req_cmd.warp_factor = req_warp_factor;

   assign advance   = cmd_valid && (!rsp_valid || !rsp_stall);
   assign req_stall = cmd_valid && !advance;

   rtfsc_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_cmd   (req_cmd),
      .advance   (advance),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   rtfsc_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fire             (advance),
      .cmd              (cmd),
      .rsp              (eval_rsp)
   );

   rtfsc_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rsp_in_data (eval_rsp),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign rsp_ticks_to_run = rsp.ticks_to_run;
   assign rsp_accepted     = rsp.accepted;

endmodule
